// ===== rtl/core/particle_collision_response_assert.svh =====
`ifndef PARTICLE_COLLISION_RESPONSE_ASSERT_SVH
`define PARTICLE_COLLISION_RESPONSE_ASSERT_SVH

// cond implies expr in the same cycle, outside reset
`define PCR_ASSERT_IMP(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("pcr assertion failed");

// expr holds in the cycle after reset is seen
`define PCR_ASSERT_RST(label, expr) \
  label: assert property (@(posedge clk) !rst_n |=> (expr)) \
    else $error("pcr reset assertion failed");

`endif

// ===== rtl/core/pcr_pkg.sv =====
package pcr_pkg;

  localparam int IN_W        = 344;
  localparam int OUT_W       = 192;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_BITS    = 16;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [1:0] {
    REG_RESTITUTION = 2'd0,
    REG_FRICTION    = 2'd1,
    REG_RADIUS      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] surf;
    logic [2:0][38:0] rvn;
    logic [2:0][39:0] rvt;
    logic             neg;
    logic [3:0]       shift;
    logic [56:0]      num;
  } side_t;

  function automatic logic [31:0] sat32(input logic signed [43:0] x);
    logic [31:0] res;
    if (x[43:31] == {13{x[43]}}) begin
      res = x[31:0];
    end else if (x[43]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7fff_ffff;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/pcr_front.sv =====
module pcr_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [pcr_pkg::IN_W-1:0]  in_data,
  input  logic [16:0]               restitution,
  input  logic [17:0]               friction,
  input  logic [30:0]               radius,
  output logic                      out_valid,
  output logic [63:0]               out_sum,
  output pcr_pkg::side_t            out_side
);

  logic signed [31:0] p_in [3];
  logic signed [17:0] n_in [3];
  logic signed [31:0] s_in [3];
  logic signed [31:0] v_in [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_in[i] = in_data[32*i +: 32];
      n_in[i] = in_data[96 + 18*i +: 18];
      s_in[i] = in_data[150 + 32*i +: 32];
      v_in[i] = in_data[246 + 32*i +: 32];
    end
  end

  // stage A: relative velocity, dot terms, push-out terms
  logic               vld_a_r;
  logic signed [31:0] p_a_r [3];
  logic signed [17:0] n_a_r [3];
  logic signed [31:0] s_a_r [3];
  logic signed [31:0] v_a_r [3];
  logic signed [32:0] rv_a_r [3];
  logic signed [32:0] rv_a_nxt [3];
  logic signed [50:0] dp_a_r [3];
  logic signed [50:0] dp_a_nxt [3];
  logic signed [49:0] op_a_r [3];
  logic signed [49:0] op_a_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv_a_nxt[i] = 33'(v_in[i]) - 33'(s_in[i]);
      dp_a_nxt[i] = n_in[i] * rv_a_nxt[i];
      op_a_nxt[i] = $signed({1'b0, radius}) * n_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_a_r  <= p_in;
      n_a_r  <= n_in;
      s_a_r  <= s_in;
      v_a_r  <= v_in;
      rv_a_r <= rv_a_nxt;
      dp_a_r <= dp_a_nxt;
      op_a_r <= op_a_nxt;
    end
  end

  // stage B: normal speed, corrected position
  logic               vld_b_r;
  logic signed [36:0] dn_b_r;
  logic signed [36:0] dn_b_nxt;
  logic [2:0][31:0]   pos_b_r;
  logic [2:0][31:0]   pos_b_nxt;
  logic signed [32:0] rv_b_r [3];
  logic signed [17:0] n_b_r [3];
  logic signed [31:0] s_b_r [3];
  logic signed [31:0] v_b_r [3];

  always_comb begin
    logic signed [52:0] acc;
    logic signed [43:0] psum;
    acc = 53'(dp_a_r[0]) + 53'(dp_a_r[1]) + 53'(dp_a_r[2]);
    dn_b_nxt = 37'((acc + 53'sd32768) >>> 16);
    for (int i = 0; i < 3; i++) begin
      psum = 44'(p_a_r[i]) + 44'((op_a_r[i] + 50'sd65536) >>> 17);
      pos_b_nxt[i] = pcr_pkg::sat32(psum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_b_r  <= dn_b_nxt;
      pos_b_r <= pos_b_nxt;
      rv_b_r  <= rv_a_r;
      n_b_r   <= n_a_r;
      s_b_r   <= s_a_r;
      v_b_r   <= v_a_r;
    end
  end

  // stage C: normal projection products, bounce magnitude product
  logic               vld_c_r;
  pcr_pkg::side_t     sd_c_r;
  pcr_pkg::side_t     sd_c_nxt;
  logic signed [32:0] rv_c_r [3];
  logic signed [54:0] rvnp_c_r [3];
  logic signed [54:0] rvnp_c_nxt [3];
  logic [54:0]        dvnp_c_r;
  logic [54:0]        dvnp_c_nxt;

  always_comb begin
    logic [36:0] adn;
    adn = dn_b_r[36] ? 37'(-dn_b_r) : 37'(dn_b_r);
    dvnp_c_nxt = 55'(18'(pcr_pkg::ONE_Q16) + 18'(restitution)) * 55'(adn);
    sd_c_nxt = '0;
    sd_c_nxt.pos = pos_b_r;
    sd_c_nxt.neg = dn_b_r[36];
    for (int i = 0; i < 3; i++) begin
      rvnp_c_nxt[i] = dn_b_r * n_b_r[i];
      sd_c_nxt.vel[i]  = v_b_r[i];
      sd_c_nxt.surf[i] = s_b_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_c_r   <= sd_c_nxt;
      rv_c_r   <= rv_b_r;
      rvnp_c_r <= rvnp_c_nxt;
      dvnp_c_r <= dvnp_c_nxt;
    end
  end

  // stage D: normal and tangential parts
  logic           vld_d_r;
  pcr_pkg::side_t sd_d_r;
  pcr_pkg::side_t sd_d_nxt;
  logic [39:0]    a_d_r [3];
  logic [39:0]    a_d_nxt [3];
  logic [38:0]    dvn_d_r;

  always_comb begin
    logic signed [38:0] rvn;
    logic signed [39:0] rvt;
    sd_d_nxt = sd_c_r;
    for (int i = 0; i < 3; i++) begin
      rvn = 39'((rvnp_c_r[i] + 55'sd32768) >>> 16);
      rvt = 40'(rv_c_r[i]) - 40'(rvn);
      sd_d_nxt.rvn[i] = rvn;
      sd_d_nxt.rvt[i] = rvt;
      a_d_nxt[i] = rvt[39] ? 40'(-rvt) : 40'(rvt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_d_r  <= sd_d_nxt;
      a_d_r   <= a_d_nxt;
      dvn_d_r <= 39'(dvnp_c_r >> 16);
    end
  end

  // stage E: friction numerator, magnitude range shift
  logic           vld_e_r;
  pcr_pkg::side_t sd_e_r;
  pcr_pkg::side_t sd_e_nxt;
  logic [39:0]    a_e_r [3];

  always_comb begin
    logic [39:0] m;
    logic [3:0]  sh;
    m = a_d_r[0];
    if (a_d_r[1] > m) begin
      m = a_d_r[1];
    end
    if (a_d_r[2] > m) begin
      m = a_d_r[2];
    end
    sh = 4'd0;
    for (int b = 31; b < 40; b++) begin
      if (m[b]) begin
        sh = 4'(b - 30);
      end
    end
    sd_e_nxt = sd_d_r;
    sd_e_nxt.shift = sh;
    sd_e_nxt.num = 57'(friction) * 57'(dvn_d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
    end else if (en) begin
      vld_e_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_e_r <= sd_e_nxt;
      a_e_r  <= a_d_r;
    end
  end

  // stage F: squares of scaled components
  logic           vld_f_r;
  pcr_pkg::side_t sd_f_r;
  logic [61:0]    sq_f_r [3];
  logic [61:0]    sq_f_nxt [3];

  always_comb begin
    logic [30:0] c;
    for (int i = 0; i < 3; i++) begin
      c = 31'(a_e_r[i] >> sd_e_r.shift);
      sq_f_nxt[i] = 62'(c) * 62'(c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f_r <= 1'b0;
    end else if (en) begin
      vld_f_r <= vld_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_f_r <= sd_e_r;
      sq_f_r <= sq_f_nxt;
    end
  end

  // stage G: sum of squares
  logic           vld_g_r;
  pcr_pkg::side_t sd_g_r;
  logic [63:0]    sum_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_g_r <= 1'b0;
    end else if (en) begin
      vld_g_r <= vld_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_g_r  <= sd_f_r;
      sum_g_r <= 64'(sq_f_r[0]) + 64'(sq_f_r[1]) + 64'(sq_f_r[2]);
    end
  end

  assign out_valid = vld_g_r;
  assign out_sum   = sum_g_r;
  assign out_side  = sd_g_r;

endmodule

// ===== rtl/core/pcr_sqrt.sv =====
`include "particle_collision_response_assert.svh"

module pcr_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [63:0]    in_x,
  input  pcr_pkg::side_t in_side,
  output logic           out_valid,
  output logic [31:0]    out_root,
  output pcr_pkg::side_t out_side
);

  localparam int N = pcr_pkg::SQRT_STAGES;

  logic [N-1:0]   vld_r;
  logic [33:0]    rem_r  [N];
  logic [31:0]    root_r [N];
  logic [63:0]    x_r    [N-1];
  pcr_pkg::side_t sd_r   [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic           vld_prev;
    logic [33:0]    rem_prev;
    logic [31:0]    root_prev;
    logic [63:0]    x_prev;
    pcr_pkg::side_t sd_prev;
    logic [34:0]    cur;
    logic [34:0]    trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign x_prev    = in_x;
      assign sd_prev   = in_side;
    end else begin : g_next
      assign vld_prev  = vld_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign x_prev    = x_r[k-1];
      assign sd_prev   = sd_r[k-1];
    end

    assign cur   = {rem_prev[32:0], x_prev[63:62]};
    assign trial = {1'b0, root_prev, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 34'(cur - trial) : cur[33:0];
        root_r[k] <= {root_prev[30:0], ge};
        sd_r[k]   <= sd_prev;
      end
    end

    if (k < N - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k] <= {x_prev[61:0], 2'b00};
        end
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = sd_r[N-1];

  `PCR_ASSERT_IMP(a_sqrt_rem_bound, vld_r[N-1], ({1'b0, rem_r[N-1]} <= {2'b0, root_r[N-1], 1'b0}))

endmodule

// ===== rtl/core/pcr_div.sv =====
`include "particle_collision_response_assert.svh"

module pcr_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [40:0]    in_den,
  input  pcr_pkg::side_t in_side,
  output logic           out_valid,
  output logic [16:0]    out_scale,
  output pcr_pkg::side_t out_side
);

  localparam int N = pcr_pkg::DIV_BITS;

  // stage 0: saturation and zero-divisor checks
  logic           vld0_r;
  logic [56:0]    rem0_r;
  logic [40:0]    den0_r;
  logic           zero0_r;
  logic           over0_r;
  pcr_pkg::side_t sd0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r  <= in_side.num;
      den0_r  <= in_den;
      zero0_r <= (in_den == '0);
      over0_r <= (in_side.num >= {in_den, 16'b0});
      sd0_r   <= in_side;
    end
  end

  logic [N-1:0]   vld_r;
  logic [56:0]    rem_r  [N];
  logic [40:0]    den_r  [N];
  logic [N-1:0]   q_r    [N];
  logic [N-1:0]   zero_r;
  logic [N-1:0]   over_r;
  pcr_pkg::side_t sd_r   [N];

  for (genvar j = 0; j < N; j++) begin : g_bit
    localparam int B = N - 1 - j;
    logic           vld_prev;
    logic [56:0]    rem_prev;
    logic [40:0]    den_prev;
    logic [N-1:0]   q_prev;
    logic           zero_prev;
    logic           over_prev;
    pcr_pkg::side_t sd_prev;
    logic [56:0]    sh;
    logic           ge;
    logic [N-1:0]   q_nxt;

    if (j == 0) begin : g_first
      assign vld_prev  = vld0_r;
      assign rem_prev  = rem0_r;
      assign den_prev  = den0_r;
      assign q_prev    = '0;
      assign zero_prev = zero0_r;
      assign over_prev = over0_r;
      assign sd_prev   = sd0_r;
    end else begin : g_next
      assign vld_prev  = vld_r[j-1];
      assign rem_prev  = rem_r[j-1];
      assign den_prev  = den_r[j-1];
      assign q_prev    = q_r[j-1];
      assign zero_prev = zero_r[j-1];
      assign over_prev = over_r[j-1];
      assign sd_prev   = sd_r[j-1];
    end

    assign sh = 57'(den_prev) << B;
    assign ge = !zero_prev && !over_prev && (rem_prev >= sh);

    always_comb begin
      q_nxt    = q_prev;
      q_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? (rem_prev - sh) : rem_prev;
        den_r[j]  <= den_prev;
        q_r[j]    <= q_nxt;
        zero_r[j] <= zero_prev;
        over_r[j] <= over_prev;
        sd_r[j]   <= sd_prev;
      end
    end
  end

  always_comb begin
    if (zero_r[N-1]) begin
      out_scale = pcr_pkg::ONE_Q16;
    end else if (over_r[N-1]) begin
      out_scale = '0;
    end else begin
      out_scale = pcr_pkg::ONE_Q16 - 17'(q_r[N-1]);
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_side  = sd_r[N-1];

  `PCR_ASSERT_IMP(a_div_rem_bound, (vld_r[N-1] && !zero_r[N-1] && !over_r[N-1]), (rem_r[N-1] < 57'(den_r[N-1])))

endmodule

// ===== rtl/core/pcr_out.sv =====
module pcr_out (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [16:0]               in_scale,
  input  pcr_pkg::side_t            in_side,
  input  logic [16:0]               restitution,
  output logic                      out_valid,
  output logic [pcr_pkg::OUT_W-1:0] out_data
);

  logic               vld1_r;
  pcr_pkg::side_t     sd1_r;
  logic signed [56:0] ne_r [3];
  logic signed [56:0] ne_nxt [3];
  logic signed [57:0] te_r [3];
  logic signed [57:0] te_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ne_nxt[i] = $signed({1'b0, restitution}) * $signed(in_side.rvn[i]);
      te_nxt[i] = $signed(in_side.rvt[i]) * $signed({1'b0, in_scale});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r <= in_side;
      ne_r  <= ne_nxt;
      te_r  <= te_nxt;
    end
  end

  logic                      vld2_r;
  logic [pcr_pkg::OUT_W-1:0] data2_r;
  logic [pcr_pkg::OUT_W-1:0] data2_nxt;

  always_comb begin
    logic signed [58:0] nn;
    logic signed [57:0] tt;
    logic signed [43:0] tot;
    data2_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      nn  = (-(59'(ne_r[i])) + 59'sd32768) >>> 16;
      tt  = (te_r[i] + 58'sd32768) >>> 16;
      tot = 44'(nn) + 44'(tt) + 44'($signed(sd1_r.surf[i]));
      data2_nxt[32*i +: 32] = sd1_r.pos[i];
      data2_nxt[96 + 32*i +: 32] = sd1_r.neg ? pcr_pkg::sat32(tot) : sd1_r.vel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data2_r <= data2_nxt;
    end
  end

  assign out_valid = vld2_r;
  assign out_data  = data2_r;

endmodule

// ===== rtl/core/particle_collision_response.sv =====
// A request runs through pcr_front, pcr_sqrt, pcr_div and pcr_out before out_tvalid rises.
// Throughput: one request per cycle unless out_tready stalls; the 32-step square root
// and the 16-step quotient are fully pipelined, one step per stage; all stages advance
// together. A stall on out_tready holds every stage; in_tready follows it.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
`include "particle_collision_response_assert.svh"

module particle_collision_response (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // hit_px, hit_py, hit_pz, norm_x, norm_y, norm_z, surf_vx, surf_vy, surf_vz,
  // vel_x, vel_y, vel_z, 2 unused bits
  input  logic [pcr_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // pos_x, pos_y, pos_z, out_vx, out_vy, out_vz
  output logic [pcr_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [30:0]               cfg_wdata
);

  logic [16:0] restitution_r;
  logic [17:0] friction_r;
  logic [30:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restitution_r <= '0;
      friction_r    <= '0;
      radius_r      <= 31'd3277;
    end else if (cfg_we) begin
      unique case (pcr_pkg::cfg_reg_t'(cfg_addr))
        pcr_pkg::REG_RESTITUTION: restitution_r <= cfg_wdata[16:0];
        pcr_pkg::REG_FRICTION:    friction_r    <= cfg_wdata[17:0];
        pcr_pkg::REG_RADIUS:      radius_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic           fr_valid;
  logic [63:0]    fr_sum;
  pcr_pkg::side_t fr_side;

  pcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .in_data     (in_tdata),
    .restitution (restitution_r),
    .friction    (friction_r),
    .radius      (radius_r),
    .out_valid   (fr_valid),
    .out_sum     (fr_sum),
    .out_side    (fr_side)
  );

  logic           sq_valid;
  logic [31:0]    sq_root;
  pcr_pkg::side_t sq_side;

  pcr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_x      (fr_sum),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic [40:0] vt;
  assign vt = 41'(sq_root) << sq_side.shift;

  logic           dv_valid;
  logic [16:0]    dv_scale;
  pcr_pkg::side_t dv_side;

  pcr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_den    (vt),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_scale (dv_scale),
    .out_side  (dv_side)
  );

  pcr_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (dv_valid),
    .in_scale    (dv_scale),
    .in_side     (dv_side),
    .restitution (restitution_r),
    .out_valid   (out_tvalid),
    .out_data    (out_tdata)
  );

  `PCR_ASSERT_RST(a_rst_clears_out, (!out_tvalid && in_tready))

endmodule
